### rtl/core/lfps_pkg.sv
`default_nettype none
package lfps_pkg;

	localparam int ERR_FRAC  = 8;
	localparam int GAIN_FRAC = 16;
	localparam int TOT_FRAC  = ERR_FRAC + GAIN_FRAC;
	localparam int ERR_ONE   = 1 << ERR_FRAC;

	localparam int SENS_W  = 5;
	localparam int GAIN_W  = 24;
	localparam int SPEED_W = 8;
	localparam int LIM_W   = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam int ERR_W   = ERR_FRAC + 6;
	localparam int DERIV_W = ERR_W + 1;
	localparam int INT_W   = LIM_W + 1;
	localparam int SUM_W   = ((ERR_W > INT_W) ? ERR_W : INT_W) + 1;
	localparam int OP_W    = SUM_W;
	localparam int PROD_W  = GAIN_W + 1 + OP_W;
	localparam int BASE_W  = SPEED_W + TOT_FRAC + 1;
	localparam int ACC_W   = ((PROD_W + 2 > BASE_W) ? PROD_W + 2 : BASE_W) + 1;

	localparam logic signed [ERR_W-1:0] LOST_ERR = ERR_W'(25 * ERR_ONE);

	localparam logic [GAIN_W-1:0]  PROP_GAIN_RST  = GAIN_W'(3277);
	localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST = GAIN_W'(66);
	localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST = GAIN_W'(6554);
	localparam logic [SPEED_W-1:0] MAX_SPEED_RST  = SPEED_W'(200);
	localparam logic [LIM_W-1:0]   WINDUP_RST     = LIM_W'(51200);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROP_GAIN  = 3'd0,
		REG_INTEG_GAIN = 3'd1,
		REG_DERIV_GAIN = 3'd2,
		REG_MAX_SPEED  = 3'd3,
		REG_WINDUP     = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MUL_P,
		MUL_I,
		MUL_D
	} mul_sel_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ERR,
		ST_MUL_P,
		ST_MUL_I,
		ST_MUL_D,
		ST_SUM,
		ST_DUTY
	} state_t;

	typedef struct packed {
		logic     load_in;
		logic     step_err;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     acc_clr;
		logic     acc_add;
		logic     load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_stat_t;

	// mean sensor weight per pattern, truncated toward zero; all-ones is the lost case
	function automatic logic signed [ERR_W-1:0] sensor_error(input logic [SENS_W-1:0] bits);
		logic signed [ERR_W-1:0] e;
		e = '0;
		case (bits)
			5'd1:  e = ERR_W'((20 * ERR_ONE) / 4);
			5'd2:  e = ERR_W'((10 * ERR_ONE) / 4);
			5'd3:  e = ERR_W'((30 * ERR_ONE) / 3);
			5'd5:  e = ERR_W'((20 * ERR_ONE) / 3);
			5'd6:  e = ERR_W'((10 * ERR_ONE) / 3);
			5'd7:  e = ERR_W'((30 * ERR_ONE) / 2);
			5'd8:  e = ERR_W'((-10 * ERR_ONE) / 4);
			5'd9:  e = ERR_W'((10 * ERR_ONE) / 3);
			5'd11: e = ERR_W'((20 * ERR_ONE) / 2);
			5'd12: e = ERR_W'((-10 * ERR_ONE) / 3);
			5'd13: e = ERR_W'((10 * ERR_ONE) / 2);
			5'd15: e = ERR_W'(20 * ERR_ONE);
			5'd16: e = ERR_W'((-20 * ERR_ONE) / 4);
			5'd18: e = ERR_W'((-10 * ERR_ONE) / 3);
			5'd19: e = ERR_W'((10 * ERR_ONE) / 2);
			5'd20: e = ERR_W'((-20 * ERR_ONE) / 3);
			5'd22: e = ERR_W'((-10 * ERR_ONE) / 2);
			5'd23: e = ERR_W'(10 * ERR_ONE);
			5'd24: e = ERR_W'((-30 * ERR_ONE) / 3);
			5'd25: e = ERR_W'((-10 * ERR_ONE) / 2);
			5'd26: e = ERR_W'((-20 * ERR_ONE) / 2);
			5'd28: e = ERR_W'((-30 * ERR_ONE) / 2);
			5'd29: e = ERR_W'(-10 * ERR_ONE);
			5'd30: e = ERR_W'(-20 * ERR_ONE);
			default: e = '0;
		endcase
		return e;
	endfunction

	function automatic logic [SPEED_W-1:0] clamp_duty(input logic signed [ACC_W-1:0] v,
		input logic [SPEED_W-1:0] mx);
		logic [SPEED_W-1:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > $signed({{(ACC_W-SPEED_W){1'b0}}, mx})) begin
			r = mx;
		end else begin
			r = v[SPEED_W-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### rtl/core/line_follow_pid_steering_top.sv
// an accepted item passes the error, multiply, sum and duty states before its result is valid
// items are taken one at a time, only in idle, as the single shared multiplier steps
//   through the proportional, integral and derivative terms
// reset: arst_n clears the integral and the last error and loads the register defaults
// cfg_ready is always high; a write takes effect at the next edge
`default_nettype none
module line_follow_pid_steering_top (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [lfps_pkg::SENS_W-1:0]         line_sensors,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [lfps_pkg::SPEED_W-1:0]             left_duty,
	output logic [lfps_pkg::SPEED_W-1:0]             right_duty,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [lfps_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [lfps_pkg::CFG_DATA_W-1:0]     cfg_data
);

	lfps_pkg::dp_cmd_t  cmd;
	lfps_pkg::dp_stat_t stat;

	assign cfg_ready = 1'b1;

	lfps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	lfps_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.line_sensors (line_sensors),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.left_duty    (left_duty),
		.right_duty   (right_duty)
	);

endmodule
`default_nettype wire

### rtl/core/lfps_ctrl.sv
`default_nettype none
module lfps_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire lfps_pkg::dp_stat_t stat,
	output lfps_pkg::dp_cmd_t       cmd
);

	lfps_pkg::state_t state_q;
	lfps_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lfps_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			lfps_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_nxt = lfps_pkg::ST_ERR;
				end
			end
			lfps_pkg::ST_ERR:   state_nxt = lfps_pkg::ST_MUL_P;
			lfps_pkg::ST_MUL_P: state_nxt = lfps_pkg::ST_MUL_I;
			lfps_pkg::ST_MUL_I: state_nxt = lfps_pkg::ST_MUL_D;
			lfps_pkg::ST_MUL_D: state_nxt = lfps_pkg::ST_SUM;
			lfps_pkg::ST_SUM:   state_nxt = lfps_pkg::ST_DUTY;
			lfps_pkg::ST_DUTY: begin
				if (stat.out_free) begin
					state_nxt = lfps_pkg::ST_IDLE;
				end
			end
			default: state_nxt = lfps_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.mul_sel = lfps_pkg::MUL_P;
		in_stall = 1'b1;
		case (state_q)
			lfps_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load_in = in_valid;
			end
			lfps_pkg::ST_ERR: begin
				cmd.step_err = 1'b1;
				cmd.acc_clr = 1'b1;
			end
			lfps_pkg::ST_MUL_P: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = lfps_pkg::MUL_P;
			end
			lfps_pkg::ST_MUL_I: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = lfps_pkg::MUL_I;
				cmd.acc_add = 1'b1;
			end
			lfps_pkg::ST_MUL_D: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = lfps_pkg::MUL_D;
				cmd.acc_add = 1'b1;
			end
			lfps_pkg::ST_SUM: begin
				cmd.acc_add = 1'b1;
			end
			lfps_pkg::ST_DUTY: begin
				cmd.load_out = stat.out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule
`default_nettype wire

### rtl/core/lfps_dp.sv
`default_nettype none
module lfps_dp (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire lfps_pkg::dp_cmd_t                   cmd,
	output lfps_pkg::dp_stat_t                       stat,
	input  wire logic [lfps_pkg::SENS_W-1:0]         line_sensors,
	input  wire logic                                cfg_valid,
	input  wire logic [lfps_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [lfps_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                                out_stall,
	output logic                                     out_valid,
	output logic [lfps_pkg::SPEED_W-1:0]             left_duty,
	output logic [lfps_pkg::SPEED_W-1:0]             right_duty
);

	logic [lfps_pkg::GAIN_W-1:0]  prop_gain_q;
	logic [lfps_pkg::GAIN_W-1:0]  integ_gain_q;
	logic [lfps_pkg::GAIN_W-1:0]  deriv_gain_q;
	logic [lfps_pkg::SPEED_W-1:0] max_speed_q;
	logic [lfps_pkg::LIM_W-1:0]   windup_q;

	logic [lfps_pkg::SENS_W-1:0]          sens_q;
	logic signed [lfps_pkg::ERR_W-1:0]    prev_error_q;
	logic signed [lfps_pkg::INT_W-1:0]    integ_acc_q;
	logic signed [lfps_pkg::DERIV_W-1:0]  deriv_q;
	logic signed [lfps_pkg::PROD_W-1:0]   prod_q;
	logic signed [lfps_pkg::ACC_W-1:0]    acc_q;
	logic                                 out_valid_q;
	logic [lfps_pkg::SPEED_W-1:0]         left_q;
	logic [lfps_pkg::SPEED_W-1:0]         right_q;

	logic signed [lfps_pkg::ERR_W-1:0]   err;
	logic signed [lfps_pkg::SUM_W-1:0]   int_sum;
	logic signed [lfps_pkg::SUM_W-1:0]   lim_pos;
	logic signed [lfps_pkg::SUM_W-1:0]   lim_neg;
	logic signed [lfps_pkg::SUM_W-1:0]   int_clamped;
	logic signed [lfps_pkg::DERIV_W-1:0] deriv;
	logic signed [lfps_pkg::GAIN_W:0]    gain_op;
	logic signed [lfps_pkg::OP_W-1:0]    data_op;
	logic signed [lfps_pkg::ACC_W-1:0]   base;
	logic signed [lfps_pkg::ACC_W-1:0]   left_sum;
	logic signed [lfps_pkg::ACC_W-1:0]   right_sum;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q  <= lfps_pkg::PROP_GAIN_RST;
			integ_gain_q <= lfps_pkg::INTEG_GAIN_RST;
			deriv_gain_q <= lfps_pkg::DERIV_GAIN_RST;
			max_speed_q  <= lfps_pkg::MAX_SPEED_RST;
			windup_q     <= lfps_pkg::WINDUP_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				lfps_pkg::REG_PROP_GAIN:  prop_gain_q  <= cfg_data;
				lfps_pkg::REG_INTEG_GAIN: integ_gain_q <= cfg_data;
				lfps_pkg::REG_DERIV_GAIN: deriv_gain_q <= cfg_data;
				lfps_pkg::REG_MAX_SPEED:  max_speed_q  <= cfg_data[lfps_pkg::SPEED_W-1:0];
				lfps_pkg::REG_WINDUP:     windup_q     <= cfg_data[lfps_pkg::LIM_W-1:0];
				default: ;
			endcase
		end
	end

	// error, windup clamp and derivative
	always_comb begin
		if (&sens_q) begin
			err = (prev_error_q > 0) ? lfps_pkg::LOST_ERR : -lfps_pkg::LOST_ERR;
		end else begin
			err = lfps_pkg::sensor_error(sens_q);
		end
		int_sum = lfps_pkg::SUM_W'(integ_acc_q) + lfps_pkg::SUM_W'(err);
		lim_pos = $signed({{(lfps_pkg::SUM_W-lfps_pkg::LIM_W){1'b0}}, windup_q});
		lim_neg = -lim_pos;
		if (int_sum > lim_pos) begin
			int_clamped = lim_pos;
		end else if (int_sum < lim_neg) begin
			int_clamped = lim_neg;
		end else begin
			int_clamped = int_sum;
		end
		deriv = lfps_pkg::DERIV_W'(err) - lfps_pkg::DERIV_W'(prev_error_q);
	end

	// shared multiplier operands
	always_comb begin
		case (cmd.mul_sel)
			lfps_pkg::MUL_P: begin
				gain_op = $signed({1'b0, prop_gain_q});
				data_op = lfps_pkg::OP_W'(prev_error_q);
			end
			lfps_pkg::MUL_I: begin
				gain_op = $signed({1'b0, integ_gain_q});
				data_op = lfps_pkg::OP_W'(integ_acc_q);
			end
			lfps_pkg::MUL_D: begin
				gain_op = $signed({1'b0, deriv_gain_q});
				data_op = lfps_pkg::OP_W'(deriv_q);
			end
			default: begin
				gain_op = '0;
				data_op = '0;
			end
		endcase
	end

	always_comb begin
		base = $signed({{(lfps_pkg::ACC_W-lfps_pkg::SPEED_W-lfps_pkg::TOT_FRAC){1'b0}},
			max_speed_q, {lfps_pkg::TOT_FRAC{1'b0}}});
		left_sum  = (base + acc_q) >>> lfps_pkg::TOT_FRAC;
		right_sum = (base - acc_q) >>> lfps_pkg::TOT_FRAC;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_error_q <= '0;
			integ_acc_q  <= '0;
		end else if (cmd.step_err) begin
			prev_error_q <= err;
			integ_acc_q  <= int_clamped[lfps_pkg::INT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			sens_q <= line_sensors;
		end
		if (cmd.step_err) begin
			deriv_q <= deriv;
		end
		if (cmd.mul_en) begin
			prod_q <= lfps_pkg::PROD_W'(gain_op) * lfps_pkg::PROD_W'(data_op);
		end
		if (cmd.acc_clr) begin
			acc_q <= '0;
		end else if (cmd.acc_add) begin
			acc_q <= acc_q + lfps_pkg::ACC_W'(prod_q);
		end
		if (cmd.load_out) begin
			left_q  <= lfps_pkg::clamp_duty(left_sum, max_speed_q);
			right_q <= lfps_pkg::clamp_duty(right_sum, max_speed_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stat.out_free = !out_valid_q || !out_stall;
	assign out_valid  = out_valid_q;
	assign left_duty  = left_q;
	assign right_duty = right_q;

endmodule
`default_nettype wire

### rtl/core/lfps_checker.sv
`default_nettype none
module lfps_checker (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                in_valid,
	input wire logic                                in_stall,
	input wire logic                                out_valid,
	input wire logic                                out_stall,
	input wire logic [lfps_pkg::SPEED_W-1:0]        left_duty,
	input wire logic [lfps_pkg::SPEED_W-1:0]        right_duty,
	input wire logic                                cfg_valid,
	input wire logic                                cfg_ready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(left_duty) && $stable(right_duty))
		else $error("stalled result changed");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("item accepted while previous one in flight");

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without an item in flight");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write not taken");

endmodule

bind line_follow_pid_steering_top lfps_checker u_lfps_checker (.*);
`default_nettype wire

### bench/steer_checker.sv
`timescale 1ns / 1ps
module steer_checker
	import lfps_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire logic                  in_stall,
	input  wire logic [SENS_W-1:0]     line_sensors,
	input  wire logic                  out_valid,
	input  wire logic                  out_stall,
	input  wire logic [SPEED_W-1:0]    left_duty,
	input  wire logic [SPEED_W-1:0]    right_duty,
	input  wire logic                  cfg_valid,
	input  wire logic                  cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output int                         fail_count,
	output int                         pending,
	output int                         checked
);

	localparam int WEIGHT_STEP = 10;
	localparam int MAX_SHOWN   = 40;

	typedef struct packed {
		logic [SENS_W-1:0]  sensors;
		logic [SPEED_W-1:0] left;
		logic [SPEED_W-1:0] right;
	} duty_pair_t;

	logic [GAIN_W-1:0]       kp;
	logic [GAIN_W-1:0]       ki;
	logic [GAIN_W-1:0]       kd;
	logic [SPEED_W-1:0]      top_speed;
	logic [LIM_W-1:0]        integ_limit;
	logic signed [INT_W-1:0] integ;
	logic signed [ERR_W-1:0] last_err;
	duty_pair_t              duty_q[$];
	duty_pair_t              want;

	task automatic report_mismatch(input string msg);
		if (fail_count < MAX_SHOWN) begin
			$display("mismatch at %0t: %s", $time, msg);
		end
		fail_count++;
	endtask

	function automatic logic [SPEED_W-1:0] clip_duty(input longint v);
		if (v < 0) begin
			return '0;
		end
		if (v > longint'(top_speed)) begin
			return top_speed;
		end
		return v[SPEED_W-1:0];
	endfunction

	// advances the integral and last error, returns the duty pair for this sample
	function automatic duty_pair_t steer_duties(input logic [SENS_W-1:0] bits);
		longint     wsum;
		longint     seen;
		longint     err;
		longint     acc;
		longint     lim;
		longint     corr;
		longint     base;
		int         i;
		duty_pair_t d;
		wsum = 0;
		seen = 0;
		for (i = 0; i < SENS_W; i++) begin
			if (!bits[i]) begin
				wsum += (i - 2) * WEIGHT_STEP;
				seen++;
			end
		end
		if (seen > 0) begin
			err = (wsum * ERR_ONE) / seen;
		end else if (last_err > 0) begin
			err = longint'(LOST_ERR);
		end else begin
			err = -longint'(LOST_ERR);
		end
		lim = longint'(integ_limit);
		acc = longint'(integ) + err;
		if (acc > lim) begin
			acc = lim;
		end
		if (acc < -lim) begin
			acc = -lim;
		end
		corr = longint'(kp) * err + longint'(ki) * acc
			+ longint'(kd) * (err - longint'(last_err));
		integ = acc[INT_W-1:0];
		last_err = err[ERR_W-1:0];
		base = longint'(top_speed) <<< TOT_FRAC;
		d.sensors = bits;
		d.left = clip_duty((base + corr) >>> TOT_FRAC);
		d.right = clip_duty((base - corr) >>> TOT_FRAC);
		return d;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp = PROP_GAIN_RST;
			ki = INTEG_GAIN_RST;
			kd = DERIV_GAIN_RST;
			top_speed = MAX_SPEED_RST;
			integ_limit = WINDUP_RST;
			integ = '0;
			last_err = '0;
			duty_q.delete();
			fail_count = 0;
			checked = 0;
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (duty_q.size() == 0) begin
					report_mismatch($sformatf("duty pair %0d/%0d with nothing expected",
						left_duty, right_duty));
				end else begin
					want = duty_q.pop_front();
					checked++;
					if (left_duty !== want.left) begin
						report_mismatch($sformatf("sensors %b: left_duty %0d, expected %0d",
							want.sensors, left_duty, want.left));
					end
					if (right_duty !== want.right) begin
						report_mismatch($sformatf("sensors %b: right_duty %0d, expected %0d",
							want.sensors, right_duty, want.right));
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_PROP_GAIN:  kp = cfg_data[GAIN_W-1:0];
					REG_INTEG_GAIN: ki = cfg_data[GAIN_W-1:0];
					REG_DERIV_GAIN: kd = cfg_data[GAIN_W-1:0];
					REG_MAX_SPEED:  top_speed = cfg_data[SPEED_W-1:0];
					REG_WINDUP:     integ_limit = cfg_data[LIM_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				duty_q.push_back(steer_duties(line_sensors));
			end
			pending <= duty_q.size();
		end
	end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
module tb;
	import lfps_pkg::*;

	localparam int CYCLE_LIMIT      = 400000;
	localparam int PHASES           = 8;
	localparam int RANDOM_PER_PHASE = 154;
	localparam int SETTLE_CYCLES    = 12;
	localparam logic [SENS_W-1:0] NO_LINE = '1;

	typedef enum logic [1:0] {
		FLOW,
		HOLD,
		CHOPPY
	} stall_mode_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic [SENS_W-1:0]     line_sensors = '0;
	logic                  out_stall = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	wire logic             in_stall;
	wire logic             out_valid;
	wire logic             cfg_ready;
	wire logic [SPEED_W-1:0] left_duty;
	wire logic [SPEED_W-1:0] right_duty;

	int fail_count;
	int pending;
	int checked;

	stall_mode_t stall_mode = FLOW;
	int          stall_run = 0;
	int          burst_left = 0;
	int          samples_sent = 0;
	int          settings = 0;
	int          phase;

	// line lost from each side, every single sensor, adjacent pairs, truncating means
	logic [SENS_W-1:0] warmup [22] = '{
		5'b11111, 5'b11111, 5'b11110, 5'b01111, 5'b11111, 5'b11111,
		5'b00000, 5'b11111, 5'b11011, 5'b11101, 5'b10111, 5'b11100,
		5'b00111, 5'b11000, 5'b10010, 5'b01001, 5'b01110, 5'b00001,
		5'b10000, 5'b00110, 5'b10101, 5'b01010
	};

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	line_follow_pid_steering_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.line_sensors (line_sensors),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.left_duty    (left_duty),
		.right_duty   (right_duty),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	steer_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.line_sensors (line_sensors),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.left_duty    (left_duty),
		.right_duty   (right_duty),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.pending      (pending),
		.checked      (checked)
	);

	// receiver stall pattern: free runs, solid holds and choppy stretches
	always @(posedge clk) begin
		if (stall_run == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 2));
			stall_run <= $urandom_range(1, 40);
		end else begin
			stall_run <= stall_run - 1;
		end
		case (stall_mode)
			HOLD:    out_stall <= 1'b1;
			CHOPPY:  out_stall <= 1'($urandom_range(0, 1));
			default: out_stall <= 1'b0;
		endcase
	end

	task automatic send_item(input logic [SENS_W-1:0] bits);
		int gap;
		in_valid <= 1'b1;
		line_sensors <= bits;
		do @(posedge clk); while (in_stall);
		samples_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 20);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic run_random(input int n);
		int                sent;
		int                run;
		int                pos;
		int                r;
		logic [SENS_W-1:0] pat;
		sent = 0;
		while (sent < n) begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				pat = SENS_W'($urandom_range(0, (1 << SENS_W) - 1));
			end else if (r < 80) begin
				pos = $urandom_range(0, SENS_W - 1);
				pat = NO_LINE;
				pat[pos] = 1'b0;
				if (pos < SENS_W - 1 && $urandom_range(0, 1) == 1) begin
					pat[pos + 1] = 1'b0;
				end
			end else begin
				pat = NO_LINE;
			end
			run = $urandom_range(1, 12);
			while (run > 0 && sent < n) begin
				send_item(pat);
				run--;
				sent++;
			end
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic load_settings(input logic [GAIN_W-1:0] p, input logic [GAIN_W-1:0] i,
		input logic [GAIN_W-1:0] d, input logic [SPEED_W-1:0] s,
		input logic [LIM_W-1:0] w, input bit poke_unused);
		int idx;
		write_reg(REG_PROP_GAIN, p);
		write_reg(REG_INTEG_GAIN, i);
		write_reg(REG_DERIV_GAIN, d);
		write_reg(REG_MAX_SPEED, {16'($urandom), s});
		write_reg(REG_WINDUP, {8'($urandom), w});
		if (poke_unused) begin
			for (idx = REG_WINDUP + 1; idx < (1 << CFG_IDX_W); idx++) begin
				write_reg(idx[CFG_IDX_W-1:0], CFG_DATA_W'($urandom));
			end
		end
		cfg_valid <= 1'b0;
		settings++;
	endtask

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("run timed out after %0d cycles", CYCLE_LIMIT);
		$display("FAIL");
		$finish;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (warmup[k]) begin
			send_item(warmup[k]);
		end
		for (phase = 0; phase < PHASES; phase++) begin
			drain();
			case (phase)
				0: load_settings(PROP_GAIN_RST, INTEG_GAIN_RST, DERIV_GAIN_RST,
					MAX_SPEED_RST, WINDUP_RST, 1'b1);
				1: load_settings('1, '1, '1, '1, '1, 1'b0);
				2: load_settings('0, '0, '0, '0, '0, 1'b0);
				3: load_settings(PROP_GAIN_RST, GAIN_W'($urandom_range(1, 20000)),
					DERIV_GAIN_RST, '1, '0, 1'b0);
				4: load_settings(GAIN_W'($urandom_range(0, 20000)),
					GAIN_W'($urandom_range(0, 20000)),
					GAIN_W'($urandom_range(0, 20000)), SPEED_W'($urandom_range(100, 255)),
					LIM_W'($urandom_range(1, 2000)), 1'b0);
				5: load_settings(GAIN_W'($urandom_range(0, (1 << GAIN_W) - 1)),
					GAIN_W'($urandom_range(0, (1 << GAIN_W) - 1)),
					GAIN_W'($urandom_range(0, (1 << GAIN_W) - 1)),
					SPEED_W'($urandom_range(0, 255)), LIM_W'($urandom_range(0, 65535)),
					1'b0);
				6: load_settings(GAIN_W'($urandom_range(0, 5000)),
					GAIN_W'($urandom_range(1000, 100000)),
					GAIN_W'($urandom_range(0, 20000)), 8'd1,
					LIM_W'($urandom_range(0, 65535)), 1'b0);
				default: load_settings(GAIN_W'($urandom_range(0, 65535)),
					GAIN_W'($urandom_range(0, 65535)),
					GAIN_W'($urandom_range(0, 65535)), SPEED_W'($urandom_range(0, 255)),
					LIM_W'($urandom_range(0, 65535)), 1'b1);
			endcase
			run_random(RANDOM_PER_PHASE);
		end
		drain();
		$display("%0d sensor samples sent, %0d duty pairs compared, %0d register settings",
			samples_sent, checked, settings + 1);
		$display("settings spanned gain, speed and windup extremes, zero windup, unused indexes");
		if (fail_count == 0 && pending == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

### sim.f
rtl/core/lfps_pkg.sv
rtl/core/lfps_ctrl.sv
rtl/core/lfps_dp.sv
rtl/core/line_follow_pid_steering_top.sv
rtl/core/lfps_checker.sv
bench/steer_checker.sv
bench/tb.sv
